/* hdl/iee_pkg.sv */
// Shared types, codes and the precedence table of the infix expression evaluator
`timescale 1ns / 1ps
package iee_pkg;

  typedef logic [7:0] symbol_t;
  typedef logic [2:0] status_t;
  typedef logic [2:0] opc_t;
  typedef logic [1:0] prec_t;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_BADCHAR   = 3'd1;
  localparam status_t ST_MALFORMED = 3'd2;
  localparam status_t ST_OVERFLOW  = 3'd3;
  localparam status_t ST_DIVZERO   = 3'd4;

  localparam opc_t C_ADD  = 3'd0;
  localparam opc_t C_SUB  = 3'd1;
  localparam opc_t C_MUL  = 3'd2;
  localparam opc_t C_DIV  = 3'd3;
  localparam opc_t C_LPAR = 3'd4;
  localparam opc_t C_RPAR = 3'd5;
  localparam opc_t C_END  = 3'd6;

  localparam prec_t P_PUSH   = 2'd0;
  localparam prec_t P_MATCH  = 2'd1;
  localparam prec_t P_REDUCE = 2'd2;
  localparam prec_t P_UNDEF  = 2'd3;

  localparam symbol_t CH_HASH  = 8'h23;
  localparam symbol_t CH_LPAR  = 8'h28;
  localparam symbol_t CH_RPAR  = 8'h29;
  localparam symbol_t CH_ADD   = 8'h2B;
  localparam symbol_t CH_SUB   = 8'h2D;
  localparam symbol_t CH_MUL   = 8'h2A;
  localparam symbol_t CH_DIV   = 8'h2F;
  localparam symbol_t CH_ZERO  = 8'h30;
  localparam symbol_t CH_NINE  = 8'h39;
  localparam symbol_t CH_SPACE = 8'h20;
  localparam symbol_t CH_TAB   = 8'h09;
  localparam symbol_t CH_CR    = 8'h0D;

  function automatic prec_t precede(input logic has_top, input opc_t top, input opc_t c);
    prec_t p;
    if (!has_top) begin
      p = (c == C_END) ? P_MATCH : ((c == C_RPAR) ? P_UNDEF : P_PUSH);
    end else if (top == C_ADD || top == C_SUB) begin
      p = (c == C_MUL || c == C_DIV || c == C_LPAR) ? P_PUSH : P_REDUCE;
    end else if (top == C_MUL || top == C_DIV) begin
      p = (c == C_LPAR) ? P_PUSH : P_REDUCE;
    end else if (c == C_RPAR) begin
      p = P_MATCH;
    end else if (c == C_END) begin
      p = P_UNDEF;
    end else begin
      p = P_PUSH;
    end
    return p;
  endfunction

endpackage

/* hdl/iee_in_if.sv */
// Input channel carrying one character per beat
`timescale 1ns / 1ps
interface iee_in_if;
  logic              valid;
  logic              ready;
  iee_pkg::symbol_t  symbol;
  modport source(output valid, output symbol, input ready);
  modport sink(input valid, input symbol, output ready);
endinterface

/* hdl/iee_out_if.sv */
// Result channel carrying the value and status of one expression per beat
`timescale 1ns / 1ps
interface iee_out_if #(parameter int VALUE_WIDTH = 48);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  iee_pkg::status_t              status;
  modport source(output valid, output value, output status, input ready);
  modport sink(input valid, input value, input status, output ready);
endinterface

/* hdl/iee_ram.sv */
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module iee_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/infix_expression_evaluator.sv */
// Infix expression evaluator: two stacks, precedence sequencer, shared iterative arithmetic unit
// Sequencing: a space, digit or error-masked character is taken in S_IDLE; an operator is
// accepted, then pushed or finished in S_OP; a parenthesis pair is dropped via S_POPLD; a
// reduction runs S_LOAD, then for multiply or divide the shift-add / divide unit and S_SAT.
// S_EMIT sends the result, waiting while one is held; ready only while the sequencer idles.
// Reset: synchronous active low; empties both stacks, clears the error and the result valid flag.
`timescale 1ns / 1ps
module infix_expression_evaluator #(
  parameter int OPERATOR_DEPTH = 32,
  parameter int OPERAND_DEPTH  = 32,
  parameter int VALUE_WIDTH    = 48,
  parameter int FRACTION_BITS  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  iee_in_if.sink    in_ch,
  iee_out_if.source out_ch
);
  localparam int W   = VALUE_WIDTH;
  localparam int F   = FRACTION_BITS;
  localparam int AW  = 2 * W + F;
  localparam int N   = W + F;
  localparam int IW  = $clog2(N + 1);
  localparam int OCW = $clog2(OPERATOR_DEPTH + 1);
  localparam int NCW = $clog2(OPERAND_DEPTH + 1);
  localparam int OAW = $clog2(OPERATOR_DEPTH);
  localparam int NAW = $clog2(OPERAND_DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_OP    = 4'd1;
  localparam logic [3:0] S_LOAD  = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_SAT   = 4'd5;
  localparam logic [3:0] S_POPLD = 4'd6;
  localparam logic [3:0] S_EMIT  = 4'd7;

  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  logic [3:0]             state_r, state_nxt;
  iee_pkg::opc_t          code_r, code_nxt;
  iee_pkg::status_t       err_r, err_nxt;
  logic [OCW-1:0]         ocnt_r, ocnt_nxt;
  logic [NCW-1:0]         ncnt_r, ncnt_nxt;
  iee_pkg::opc_t          optop_r, optop_nxt;
  iee_pkg::opc_t          nextop_r, nextop_nxt;
  logic [W-1:0]           top_r, top_nxt;
  logic [W-1:0]           a_r, a_nxt;
  logic [W-1:0]           d_r, d_nxt;
  logic [W-1:0]           rem_r, rem_nxt;
  logic                   neg_r, neg_nxt;
  logic [AW-1:0]          sh_r, sh_nxt;
  logic [AW-1:0]          acc_r, acc_nxt;
  logic [IW-1:0]          it_r, it_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [W-1:0]           out_value_r, out_value_nxt;
  iee_pkg::status_t       out_status_r, out_status_nxt;

  logic                   op_we, nd_we;
  logic [OAW-1:0]         op_waddr, op_raddr;
  logic [NAW-1:0]         nd_waddr, nd_raddr;
  iee_pkg::opc_t          op_rdata;
  logic [W-1:0]           nd_rdata;

  iee_pkg::symbol_t       sym;
  iee_pkg::prec_t         prec;
  logic [W:0]             sum;
  logic [W-1:0]           mag_l, mag_t;
  logic [W:0]             rr, diff;
  logic [AW-1:0]          dig, satmag;
  iee_pkg::status_t       emit_status;

  function automatic logic [W-1:0] sat_mag(input logic neg, input logic [AW-1:0] mag);
    logic [W-1:0] v;
    if (|mag[AW-1:W-1]) begin
      v = neg ? VMIN : VMAX;
    end else begin
      v = neg ? (~mag[W-1:0] + 1'b1) : mag[W-1:0];
    end
    return v;
  endfunction

  iee_ram #(.WIDTH(3), .DEPTH(OPERATOR_DEPTH)) u_op_ram (
    .clk(clk), .we(op_we), .waddr(op_waddr), .wdata(optop_r),
    .raddr(op_raddr), .rdata(op_rdata)
  );

  iee_ram #(.WIDTH(W), .DEPTH(OPERAND_DEPTH)) u_nd_ram (
    .clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(top_r),
    .raddr(nd_raddr), .rdata(nd_rdata)
  );

  assign op_waddr = OAW'(ocnt_r - OCW'(1));
  assign nd_waddr = NAW'(ncnt_r - NCW'(1));
  assign op_raddr = OAW'(ocnt_r - OCW'(2));
  assign nd_raddr = NAW'(ncnt_r - NCW'(2));

  assign sym  = in_ch.symbol;
  assign prec = iee_pkg::precede(ocnt_r != '0, optop_r, code_r);
  assign mag_l = nd_rdata[W-1] ? (~nd_rdata + 1'b1) : nd_rdata;
  assign mag_t = top_r[W-1] ? (~top_r + 1'b1) : top_r;
  assign sum = (optop_r == iee_pkg::C_SUB) ?
               ({nd_rdata[W-1], nd_rdata} - {top_r[W-1], top_r}) :
               ({nd_rdata[W-1], nd_rdata} + {top_r[W-1], top_r});
  assign rr   = {rem_r, sh_r[N-1]};
  assign diff = rr - {1'b0, d_r};
  assign dig  = AW'(sym[3:0]) << F;
  assign satmag = (optop_r == iee_pkg::C_MUL) ? (acc_r >> F) : acc_r;
  assign emit_status = (err_r != iee_pkg::ST_OK) ? err_r :
                       ((ncnt_r != NCW'(1)) ? iee_pkg::ST_MALFORMED : iee_pkg::ST_OK);

  assign in_ch.ready   = (state_r == S_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = out_value_r;
  assign out_ch.status = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    code_nxt       = code_r;
    err_nxt        = err_r;
    ocnt_nxt       = ocnt_r;
    ncnt_nxt       = ncnt_r;
    optop_nxt      = optop_r;
    nextop_nxt     = nextop_r;
    top_nxt        = top_r;
    a_nxt          = a_r;
    d_nxt          = d_r;
    rem_nxt        = rem_r;
    neg_nxt        = neg_r;
    sh_nxt         = sh_r;
    acc_nxt        = acc_r;
    it_nxt         = it_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    op_we          = 1'b0;
    nd_we          = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (sym == iee_pkg::CH_SPACE || (sym >= iee_pkg::CH_TAB && sym <= iee_pkg::CH_CR)) begin
            state_nxt = S_IDLE;
          end else if (sym == iee_pkg::CH_HASH) begin
            code_nxt  = iee_pkg::C_END;
            state_nxt = S_OP;
          end else if (err_r != iee_pkg::ST_OK) begin
            state_nxt = S_IDLE;
          end else if (sym >= iee_pkg::CH_ZERO && sym <= iee_pkg::CH_NINE) begin
            if (ncnt_r >= NCW'(OPERAND_DEPTH)) begin
              err_nxt = iee_pkg::ST_OVERFLOW;
            end else begin
              nd_we    = (ncnt_r != '0);
              top_nxt  = sat_mag(1'b0, dig);
              ncnt_nxt = ncnt_r + NCW'(1);
            end
          end else if (sym == iee_pkg::CH_ADD) begin
            code_nxt = iee_pkg::C_ADD;  state_nxt = S_OP;
          end else if (sym == iee_pkg::CH_SUB) begin
            code_nxt = iee_pkg::C_SUB;  state_nxt = S_OP;
          end else if (sym == iee_pkg::CH_MUL) begin
            code_nxt = iee_pkg::C_MUL;  state_nxt = S_OP;
          end else if (sym == iee_pkg::CH_DIV) begin
            code_nxt = iee_pkg::C_DIV;  state_nxt = S_OP;
          end else if (sym == iee_pkg::CH_LPAR) begin
            code_nxt = iee_pkg::C_LPAR; state_nxt = S_OP;
          end else if (sym == iee_pkg::CH_RPAR) begin
            code_nxt = iee_pkg::C_RPAR; state_nxt = S_OP;
          end else begin
            err_nxt = iee_pkg::ST_BADCHAR;
          end
        end
      end
      S_OP: begin
        state_nxt = (code_r == iee_pkg::C_END) ? S_EMIT : S_IDLE;
        if (err_r == iee_pkg::ST_OK) begin
          unique case (prec)
            iee_pkg::P_PUSH: begin
              if (ocnt_r >= OCW'(OPERATOR_DEPTH)) begin
                err_nxt = iee_pkg::ST_OVERFLOW;
              end else begin
                op_we     = (ocnt_r != '0);
                optop_nxt = code_r;
                ocnt_nxt  = ocnt_r + OCW'(1);
              end
            end
            iee_pkg::P_MATCH: begin
              if (ocnt_r != '0) begin
                state_nxt = S_POPLD;
              end
            end
            iee_pkg::P_UNDEF: begin
              err_nxt = iee_pkg::ST_MALFORMED;
            end
            default: begin
              if (ncnt_r < NCW'(2)) begin
                err_nxt = iee_pkg::ST_MALFORMED;
              end else if (optop_r == iee_pkg::C_DIV && top_r == '0) begin
                err_nxt = iee_pkg::ST_DIVZERO;
              end else begin
                state_nxt = S_LOAD;
              end
            end
          endcase
        end
      end
      S_LOAD: begin
        nextop_nxt = op_rdata;
        neg_nxt    = nd_rdata[W-1] ^ top_r[W-1];
        acc_nxt    = '0;
        rem_nxt    = '0;
        if (optop_r == iee_pkg::C_MUL) begin
          a_nxt     = mag_l;
          sh_nxt    = AW'(mag_t);
          it_nxt    = IW'(W);
          state_nxt = S_MUL;
        end else if (optop_r == iee_pkg::C_DIV) begin
          d_nxt     = mag_t;
          sh_nxt    = AW'(mag_l) << F;
          it_nxt    = IW'(N);
          state_nxt = S_DIV;
        end else begin
          if (sum[W] != sum[W-1]) begin
            top_nxt = sum[W] ? VMIN : VMAX;
          end else begin
            top_nxt = sum[W-1:0];
          end
          ncnt_nxt  = ncnt_r - NCW'(1);
          ocnt_nxt  = ocnt_r - OCW'(1);
          optop_nxt = op_rdata;
          state_nxt = S_OP;
        end
      end
      S_MUL: begin
        acc_nxt = (acc_r << 1) + (sh_r[W-1] ? AW'(a_r) : AW'(0));
        sh_nxt  = sh_r << 1;
        it_nxt  = it_r - IW'(1);
        if (it_r == IW'(1)) begin
          state_nxt = S_SAT;
        end
      end
      S_DIV: begin
        if (!diff[W]) begin
          rem_nxt = diff[W-1:0];
        end else begin
          rem_nxt = rr[W-1:0];
        end
        acc_nxt = {acc_r[AW-2:0], !diff[W]};
        sh_nxt  = sh_r << 1;
        it_nxt  = it_r - IW'(1);
        if (it_r == IW'(1)) begin
          state_nxt = S_SAT;
        end
      end
      S_SAT: begin
        top_nxt   = sat_mag(neg_r, satmag);
        ncnt_nxt  = ncnt_r - NCW'(1);
        ocnt_nxt  = ocnt_r - OCW'(1);
        optop_nxt = nextop_r;
        state_nxt = S_OP;
      end
      S_POPLD: begin
        optop_nxt = op_rdata;
        ocnt_nxt  = ocnt_r - OCW'(1);
        state_nxt = S_IDLE;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = emit_status;
          out_value_nxt  = (emit_status == iee_pkg::ST_OK) ? top_r : '0;
          ncnt_nxt       = '0;
          ocnt_nxt       = '0;
          err_nxt        = iee_pkg::ST_OK;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      err_r       <= iee_pkg::ST_OK;
      ocnt_r      <= '0;
      ncnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      err_r       <= err_nxt;
      ocnt_r      <= ocnt_nxt;
      ncnt_r      <= ncnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r       <= code_nxt;
    optop_r      <= optop_nxt;
    nextop_r     <= nextop_nxt;
    top_r        <= top_nxt;
    a_r          <= a_nxt;
    d_r          <= d_nxt;
    rem_r        <= rem_nxt;
    neg_r        <= neg_nxt;
    sh_r         <= sh_nxt;
    acc_r        <= acc_nxt;
    it_r         <= it_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end
endmodule

/* tb/tb.sv */
// Self-checking testbench for the infix expression evaluator: random expressions, noise, stalls
`timescale 1ns / 1ps
module tb;

  localparam int OP_DEPTH  = 32;
  localparam int VAL_DEPTH = 32;
  localparam int VW        = 48;
  localparam int FB        = 16;
  localparam int N_ITEMS   = 1550;
  localparam longint VMAX  = (64'sd1 <<< (VW - 1)) - 1;
  localparam longint VMIN  = -VMAX - 1;

  class eval_scoreboard;
    iee_pkg::opc_t    ops[OP_DEPTH];
    int               n_ops;
    longint           vals[VAL_DEPTH];
    int               n_vals;
    iee_pkg::status_t err;
    longint           exp_value[$];
    iee_pkg::status_t exp_status[$];
    int               errors;
    int               results;
    int               n_status[8];

    function void clear();
      n_ops = 0;
      n_vals = 0;
      err = iee_pkg::ST_OK;
    endfunction

    function void flag(iee_pkg::status_t e);
      if (err == iee_pkg::ST_OK) err = e;
    endfunction

    function logic [63:0] mag(longint a);
      return a < 0 ? 64'(-a) : 64'(a);
    endfunction

    function longint clamp(bit neg, logic [127:0] m);
      if (m >= (128'd1 << (VW - 1))) return neg ? VMIN : VMAX;
      return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function iee_pkg::prec_t rank(iee_pkg::opc_t c);
      iee_pkg::opc_t t;
      if (n_ops == 0) begin
        return c == iee_pkg::C_END ? iee_pkg::P_MATCH :
               (c == iee_pkg::C_RPAR ? iee_pkg::P_UNDEF : iee_pkg::P_PUSH);
      end
      t = ops[n_ops - 1];
      if (t == iee_pkg::C_ADD || t == iee_pkg::C_SUB)
        return (c == iee_pkg::C_MUL || c == iee_pkg::C_DIV || c == iee_pkg::C_LPAR) ?
               iee_pkg::P_PUSH : iee_pkg::P_REDUCE;
      if (t == iee_pkg::C_MUL || t == iee_pkg::C_DIV)
        return c == iee_pkg::C_LPAR ? iee_pkg::P_PUSH : iee_pkg::P_REDUCE;
      if (c == iee_pkg::C_RPAR) return iee_pkg::P_MATCH;
      if (c == iee_pkg::C_END) return iee_pkg::P_UNDEF;
      return iee_pkg::P_PUSH;
    endfunction

    function void reduce();
      iee_pkg::opc_t op;
      longint lhs, rhs, r, s;
      logic [127:0] m;
      bit neg;
      if (n_vals < 2) begin
        flag(iee_pkg::ST_MALFORMED);
        return;
      end
      op = ops[n_ops - 1];
      rhs = vals[n_vals - 1];
      lhs = vals[n_vals - 2];
      if (op == iee_pkg::C_DIV && rhs == 0) begin
        flag(iee_pkg::ST_DIVZERO);
        return;
      end
      neg = (lhs < 0) != (rhs < 0);
      case (op)
        iee_pkg::C_ADD, iee_pkg::C_SUB: begin
          s = (op == iee_pkg::C_ADD) ? lhs + rhs : lhs - rhs;
          r = s > VMAX ? VMAX : (s < VMIN ? VMIN : s);
        end
        iee_pkg::C_MUL: begin
          m = ({64'd0, mag(lhs)} * {64'd0, mag(rhs)}) >> FB;
          r = clamp(neg, m);
        end
        default: begin
          m = ({64'd0, mag(lhs)} << FB) / {64'd0, mag(rhs)};
          r = clamp(neg, m);
        end
      endcase
      n_ops--;
      n_vals--;
      vals[n_vals - 1] = r;
    endfunction

    function void apply_op(iee_pkg::opc_t c);
      iee_pkg::prec_t p;
      while (err == iee_pkg::ST_OK) begin
        p = rank(c);
        case (p)
          iee_pkg::P_PUSH: begin
            if (n_ops >= OP_DEPTH) flag(iee_pkg::ST_OVERFLOW);
            else ops[n_ops++] = c;
            return;
          end
          iee_pkg::P_MATCH: begin
            if (n_ops > 0) n_ops--;
            return;
          end
          iee_pkg::P_UNDEF: begin
            flag(iee_pkg::ST_MALFORMED);
            return;
          end
          default: reduce();
        endcase
      end
    endfunction

    function void note(iee_pkg::symbol_t s);
      iee_pkg::status_t st;
      if (s == iee_pkg::CH_SPACE || (s >= iee_pkg::CH_TAB && s <= iee_pkg::CH_CR)) return;
      if (s == iee_pkg::CH_HASH) begin
        apply_op(iee_pkg::C_END);
        st = err;
        if (st == iee_pkg::ST_OK && n_vals != 1) st = iee_pkg::ST_MALFORMED;
        exp_value.push_back(st == iee_pkg::ST_OK ? vals[0] : 0);
        exp_status.push_back(st);
        clear();
        return;
      end
      if (err != iee_pkg::ST_OK) return;
      if (s >= iee_pkg::CH_ZERO && s <= iee_pkg::CH_NINE) begin
        if (n_vals >= VAL_DEPTH) flag(iee_pkg::ST_OVERFLOW);
        else vals[n_vals++] = longint'(s - iee_pkg::CH_ZERO) <<< FB;
        return;
      end
      case (s)
        iee_pkg::CH_ADD:  apply_op(iee_pkg::C_ADD);
        iee_pkg::CH_SUB:  apply_op(iee_pkg::C_SUB);
        iee_pkg::CH_MUL:  apply_op(iee_pkg::C_MUL);
        iee_pkg::CH_DIV:  apply_op(iee_pkg::C_DIV);
        iee_pkg::CH_LPAR: apply_op(iee_pkg::C_LPAR);
        iee_pkg::CH_RPAR: apply_op(iee_pkg::C_RPAR);
        default: flag(iee_pkg::ST_BADCHAR);
      endcase
    endfunction

    function void check(logic signed [VW-1:0] value, iee_pkg::status_t status);
      longint ev;
      iee_pkg::status_t es;
      longint av;
      av = longint'(value);
      if (exp_status.size() == 0) begin
        $display("%0t: result beat with nothing expected: value %0d status %0d",
                 $time, av, status);
        errors++;
        return;
      end
      ev = exp_value.pop_front();
      es = exp_status.pop_front();
      results++;
      n_status[es]++;
      if (av !== ev) begin
        $display("%0t: value mismatch: expected %0d, actual %0d", $time, ev, av);
        errors++;
      end
      if (status !== es) begin
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, es, status);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  iee_in_if in_ch();
  iee_out_if #(.VALUE_WIDTH(VW)) out_ch();

  infix_expression_evaluator #(
    .OPERATOR_DEPTH(OP_DEPTH),
    .OPERAND_DEPTH(VAL_DEPTH),
    .VALUE_WIDTH(VW),
    .FRACTION_BITS(FB)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  eval_scoreboard sb = new();
  bit quiet;
  int n_sent;
  int stall_left;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // hold ready low in random bursts, except in the quiet tail
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check(out_ch.value, out_ch.status);
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send(iee_pkg::symbol_t s);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.symbol <= s;
    do @(posedge clk); while (!in_ch.ready);
    sb.note(s);
    n_sent++;
  endtask

  task automatic send_str(string str);
    foreach (str[i]) send(iee_pkg::symbol_t'(str[i]));
  endtask

  function automatic iee_pkg::symbol_t pick_op();
    case ($urandom_range(0, 3))
      0: return iee_pkg::CH_ADD;
      1: return iee_pkg::CH_SUB;
      2: return iee_pkg::CH_MUL;
      default: return iee_pkg::CH_DIV;
    endcase
  endfunction

  function automatic void gen_expr(int depth, ref iee_pkg::symbol_t q[$]);
    int terms;
    terms = $urandom_range(1, 4);
    for (int i = 0; i < terms; i++) begin
      if (i > 0) q.push_back(pick_op());
      if ($urandom_range(0, 9) == 0) q.push_back(iee_pkg::CH_SPACE);
      if (depth > 0 && $urandom_range(0, 3) == 0) begin
        q.push_back(iee_pkg::CH_LPAR);
        gen_expr(depth - 1, q);
        q.push_back(iee_pkg::CH_RPAR);
      end else begin
        q.push_back(iee_pkg::symbol_t'(iee_pkg::CH_ZERO + $urandom_range(0, 9)));
      end
    end
  endfunction

  task automatic send_random();
    iee_pkg::symbol_t q[$];
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 2) begin
      repeat ($urandom_range(30, 34))
        q.push_back(iee_pkg::symbol_t'(iee_pkg::CH_ZERO + $urandom_range(0, 9)));
    end else if (kind < 4) begin
      repeat ($urandom_range(30, 34)) q.push_back(iee_pkg::CH_LPAR);
      q.push_back(iee_pkg::symbol_t'(iee_pkg::CH_ZERO + 1));
    end else if (kind < 6) begin
      q.push_back(iee_pkg::CH_NINE);
      repeat ($urandom_range(8, 14)) begin
        q.push_back($urandom_range(0, 1) ? iee_pkg::CH_MUL : iee_pkg::CH_DIV);
        q.push_back(iee_pkg::symbol_t'(iee_pkg::CH_ZERO + $urandom_range(1, 9)));
      end
    end else begin
      gen_expr(3, q);
    end
    if (kind >= 80) begin
      repeat ($urandom_range(1, 2)) begin
        if ($urandom_range(0, 1)) begin
          q[$urandom_range(0, q.size() - 1)] = iee_pkg::symbol_t'($urandom);
        end else begin
          q.insert($urandom_range(0, q.size()), iee_pkg::symbol_t'($urandom_range(0, 255)));
        end
      end
    end
    q.push_back(iee_pkg::CH_HASH);
    foreach (q[i]) send(q[i]);
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.symbol <= '0;
    quiet = 1'b0;
    n_sent = 0;
    sb.clear();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_str("(1+2)*3-4/5#");
    send_str("#");
    send_str(")#");
    send_str("(#");
    send_str("1 2#");
    send_str("7/0+a#");
    send_str("1+\t\n\r#");
    send_str("8\xff#");

    while (n_sent < N_ITEMS) begin
      if (n_sent > N_ITEMS * 85 / 100) quiet = 1'b1;
      send_random();
    end
    in_ch.valid <= 1'b0;

    while (sb.exp_status.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Sent %0d characters, checked %0d results", n_sent, sb.results);
    $display("Statuses ok/badchar/malformed/overflow/divzero: %0d/%0d/%0d/%0d/%0d",
             sb.n_status[0], sb.n_status[1], sb.n_status[2], sb.n_status[3],
             sb.n_status[4]);
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* sim.f */
hdl/iee_pkg.sv
hdl/iee_in_if.sv
hdl/iee_out_if.sv
hdl/iee_ram.sv
hdl/infix_expression_evaluator.sv
tb/tb.sv
